FILE: rtl/lfsrsig_pkg.sv
// Shared constants and types for the LFSR window signature checker.
package lfsrsig_pkg;

  localparam int BATCH_WORDS_DEF = 8;

  localparam int WORD_W  = 64;
  localparam int CFG_W   = 16;
  localparam int STEP_W  = 17;
  localparam int TALLY_W = 3;

  localparam logic [WORD_W-1:0]  LFSR_POLY  = 64'h231d_cee9_1262_b8a3;
  localparam logic [WORD_W-1:0]  LFSR_START = 64'hb882_0c7b_d387_e32c;
  localparam logic [TALLY_W-1:0] TALLY_MAX  = 3'd7;

  localparam logic [15:0]        WINDOW_MAX_RST     = 16'd40000;
  localparam logic [TALLY_W-1:0] MATCHES_NEEDED_RST = 3'd6;

  // configuration register indexes
  localparam logic CFG_WINDOW_MAX     = 1'b0;
  localparam logic CFG_MATCHES_NEEDED = 1'b1;

  typedef enum logic [1:0] {
    TAG_DROP,
    TAG_STORE,
    TAG_LAST
  } word_tag_t;

  typedef struct packed {
    word_tag_t         tag;
    logic [WORD_W-1:0] word;
  } q_entry_t;

endpackage

FILE: rtl/lfsrsig_word_if.sv
// Capture word channel.
interface lfsrsig_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] captured_word;

  modport source (output valid, output captured_word, input ready);
  modport sink   (input valid, input captured_word, output ready);
endinterface

FILE: rtl/lfsrsig_result_if.sv
// Search result channel.
interface lfsrsig_result_if;
  logic        valid;
  logic        ready;
  logic        passed;
  logic [2:0]  match_count;
  logic [16:0] steps_taken;

  modport source (output valid, output passed, output match_count, output steps_taken,
                  input ready);
  modport sink   (input valid, input passed, input match_count, input steps_taken,
                  output ready);
endinterface

FILE: rtl/lfsrsig_front.sv
// Front end: takes capture words and tags each by its place in the batch.
module lfsrsig_front
  import lfsrsig_pkg::*;
#(
  parameter int BATCH_WORDS = BATCH_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  lfsrsig_word_if.sink   capture,
  output logic           push_valid,
  input  logic           push_ready,
  output q_entry_t       push_data
);

  localparam int CNT_W = $clog2(BATCH_WORDS);

  logic [CNT_W-1:0] load_counter;
  logic             at_last;

  assign at_last = (load_counter == CNT_W'(BATCH_WORDS - 1));

  assign capture.ready = push_ready;
  assign push_valid    = capture.valid;

  always_comb begin
    push_data.word = capture.captured_word;
    if (load_counter == '0) begin
      push_data.tag = TAG_DROP;
    end else if (at_last) begin
      push_data.tag = TAG_LAST;
    end else begin
      push_data.tag = TAG_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_counter <= '0;
    end else if (capture.valid && push_ready) begin
      load_counter <= at_last ? '0 : load_counter + CNT_W'(1);
    end
  end

endmodule

FILE: rtl/lfsrsig_fifo.sv
// Two-entry queue between front end and search engine.
module lfsrsig_fifo
  import lfsrsig_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  q_entry_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/lfsrsig_back.sv
// Search engine: word store, LFSR walk, match tally and result register.
module lfsrsig_back
  import lfsrsig_pkg::*;
#(
  parameter int BATCH_WORDS = BATCH_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  q_entry_t             pop_data,
  input  logic [CFG_W-1:0]     window_max,
  input  logic [TALLY_W-1:0]   matches_needed,
  lfsrsig_result_if.source     result
);

  localparam int DEPTH = BATCH_WORDS - 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = (CNT_W > TALLY_W) ? CNT_W + 1 : TALLY_W + 1;

  typedef enum logic {
    B_IDLE,
    B_SEARCH
  } state_t;

  state_t              state;
  logic [WORD_W-1:0]   word_store [DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [WORD_W-1:0]   lfsr_value;
  logic [TALLY_W-1:0]  match_tally;
  logic [STEP_W-1:0]   step_counter;

  logic                res_valid;
  logic                res_passed;
  logic [TALLY_W-1:0]  res_count;
  logic [STEP_W-1:0]   res_steps;

  logic [CNT_W-1:0]    step_hits;
  logic [SUM_W-1:0]    tally_sum;
  logic [TALLY_W-1:0]  tally_new;
  logic [WORD_W-1:0]   lfsr_next;
  logic                hit;
  logic                at_end;
  logic                finish;
  logic                slot_free;
  logic                res_load;
  logic                take;

  assign pop_ready = (state == B_IDLE);
  assign take      = pop_valid && (state == B_IDLE);

  // matches of the current LFSR value against all stored words
  always_comb begin
    step_hits = '0;
    for (int k = 0; k < DEPTH; k++) begin
      step_hits = step_hits + CNT_W'(word_store[k] == lfsr_value);
    end
  end

  assign tally_sum = SUM_W'(match_tally) + SUM_W'(step_hits);
  assign tally_new = (tally_sum > SUM_W'(TALLY_MAX)) ? TALLY_MAX : tally_sum[TALLY_W-1:0];
  assign hit       = (tally_new >= matches_needed);
  assign at_end    = (step_counter == {1'b0, window_max});
  assign finish    = hit || at_end;
  assign slot_free = !res_valid || result.ready;
  assign res_load  = (state == B_SEARCH) && finish && slot_free;

  assign lfsr_next = lfsr_value[WORD_W-1]
                   ? ({lfsr_value[WORD_W-2:0], 1'b0} ^ LFSR_POLY)
                   : {lfsr_value[WORD_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (take && (pop_data.tag != TAG_DROP)) begin
      word_store[wptr] <= pop_data.word;
    end
    if (take && (pop_data.tag == TAG_LAST)) begin
      lfsr_value   <= LFSR_START;
      match_tally  <= '0;
      step_counter <= '0;
    end else if ((state == B_SEARCH) && !finish) begin
      lfsr_value   <= lfsr_next;
      match_tally  <= tally_new;
      step_counter <= step_counter + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      wptr      <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            unique case (pop_data.tag)
              TAG_STORE: wptr <= wptr + PTR_W'(1);
              TAG_LAST: begin
                wptr  <= '0;
                state <= B_SEARCH;
              end
              default: ;
            endcase
          end
        end
        B_SEARCH: begin
          // final step waits until the result register can take the word
          if (finish && slot_free) begin
            res_passed <= hit;
            res_count  <= tally_new;
            res_steps  <= hit ? step_counter : step_counter + STEP_W'(1);
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign result.valid       = res_valid;
  assign result.passed      = res_passed;
  assign result.match_count = res_count;
  assign result.steps_taken = res_steps;

`ifndef SYNTH
  a_step_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEARCH) |-> (step_counter <= {1'b0, window_max}))
    else $error("search step beyond window");

  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (take && (pop_data.tag == TAG_LAST)) |=> ((state == B_SEARCH) && (step_counter == '0)))
    else $error("search did not start at step zero");

  a_pass_tally: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_passed) |-> (res_count >= matches_needed))
    else $error("pass reported below needed tally");

  a_fail_steps: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_passed) |-> (res_steps == ({1'b0, window_max} + STEP_W'(1))))
    else $error("failed search did not cover whole window");
`endif

endmodule

FILE: rtl/lfsr_window_signature_check.sv
// LFSR window signature checker: captures a batch of words and searches an LFSR walk for them.
//
// Words arrive on the capture channel (valid/ready). The first word of each batch of
// BATCH_WORDS is dropped, the rest are kept. After the last word of a batch the engine
// walks the LFSR from its fixed start value, one step per cycle, counting stored words
// equal to the current value, and stops when the count reaches matches_needed or after
// step window_max. One result word (passed, match_count, steps_taken) then appears on
// the result channel.
// Words are taken one per cycle while the engine is idle; a two-word queue sits in front
// of it. A search examines steps 0..s, where s is steps_taken on a pass and window_max on
// a fail; the engine takes no words while it searches, so the capture channel stalls once
// the queue is full. Result valid is registered and rises after the final search step.
// A stalled result holds in its output register; the search keeps running and waits
// only at its final step until that register is free.
// Configuration (window_max, matches_needed) is written through cfg_we/cfg_index/cfg_data.
// The user must write it only while no batch is in flight; the block does not enforce this.
// Reset clears the batch position, the queue and the result register and restores
// window_max = 40000 and matches_needed = 6.
module lfsr_window_signature_check
  import lfsrsig_pkg::*;
#(
  parameter int BATCH_WORDS = BATCH_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lfsrsig_word_if.sink      capture,
  lfsrsig_result_if.source  result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0]   window_max;
  logic [TALLY_W-1:0] matches_needed;

  logic     push_valid;
  logic     push_ready;
  q_entry_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  q_entry_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max     <= WINDOW_MAX_RST;
      matches_needed <= MATCHES_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_MAX:     window_max     <= cfg_data;
        CFG_MATCHES_NEEDED: matches_needed <= cfg_data[TALLY_W-1:0];
        default: ;
      endcase
    end
  end

  lfsrsig_front #(
    .BATCH_WORDS (BATCH_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .capture    (capture),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lfsrsig_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lfsrsig_back #(
    .BATCH_WORDS (BATCH_WORDS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .window_max     (window_max),
    .matches_needed (matches_needed),
    .result         (result)
  );

endmodule
